// ===== sv/complex_arithmetic_unit_defines.svh =====
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cau_pkg.sv =====
// Shared types and defaults for the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 12;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CONJ = 3'd4,
    ACT_NEG  = 3'd5
  } action_e;

  // Per-word control that rides along the divider stages.
  typedef struct packed {
    logic is_div;
    logic dbz;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
    logic pre_ovf;
  } div_ctl_t;

endpackage

// ===== sv/cau_front.sv =====
// Front end: products, sums, non-divide results and divider setup over three stages.
module cau_front import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [2:0]                            action_i,
  input  logic signed [DATA_WIDTH-1:0]          x_re_i,
  input  logic signed [DATA_WIDTH-1:0]          x_im_i,
  input  logic signed [DATA_WIDTH-1:0]          y_re_i,
  input  logic signed [DATA_WIDTH-1:0]          y_im_i,
  output logic                                  valid_o,
  output div_ctl_t                              ctl_o,
  output logic [DATA_WIDTH-1:0]                 pre_re_o,
  output logic [DATA_WIDTH-1:0]                 pre_im_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0]     rem_re_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0]     rem_im_o,
  output logic [2*DATA_WIDTH-1:0]               den_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned SW = 2 * DATA_WIDTH + 1;
  localparam int unsigned WW = 3 * DATA_WIDTH + FRAC_BITS;

  localparam logic signed [SW-1:0] MaxV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MinV = ~MaxV;

  function automatic logic [DW:0] sat_f(input logic signed [SW-1:0] v);
    logic [DW:0] r;
    if (v > MaxV) begin
      r = {1'b1, MaxV[DW-1:0]};
    end else if (v < MinV) begin
      r = {1'b1, MinV[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  // stage 1: products
  logic                 v1_q;
  logic [2:0]           act1_q;
  logic signed [DW-1:0] xr1_q, xi1_q, yr1_q, yi1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_yr_q, p_yi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q <= action_i;
      xr1_q  <= x_re_i;
      xi1_q  <= x_im_i;
      yr1_q  <= y_re_i;
      yi1_q  <= y_im_i;
      p_rr_q <= x_re_i * y_re_i;
      p_ii_q <= x_im_i * y_im_i;
      p_ri_q <= x_re_i * y_im_i;
      p_ir_q <= x_im_i * y_re_i;
      p_yr_q <= y_re_i * y_re_i;
      p_yi_q <= y_im_i * y_im_i;
    end
  end

  // stage 2: sums and short results
  logic                 v2_q;
  logic [2:0]           act2_q;
  logic signed [SW-1:0] mre2_q, mim2_q, nre2_q, nim2_q;
  logic [PW-1:0]        den2_q;
  logic signed [DW:0]   sre2_d, sim2_d, sre2_q, sim2_q;
  logic signed [DW:0]   xr_e, xi_e, yr_e, yi_e;

  always_comb begin
    xr_e = {xr1_q[DW-1], xr1_q};
    xi_e = {xi1_q[DW-1], xi1_q};
    yr_e = {yr1_q[DW-1], yr1_q};
    yi_e = {yi1_q[DW-1], yi1_q};
    unique case (act1_q)
      ACT_ADD: begin
        sre2_d = xr_e + yr_e;
        sim2_d = xi_e + yi_e;
      end
      ACT_SUB: begin
        sre2_d = xr_e - yr_e;
        sim2_d = xi_e - yi_e;
      end
      ACT_CONJ: begin
        sre2_d = xr_e;
        sim2_d = -xi_e;
      end
      ACT_NEG: begin
        sre2_d = -xr_e;
        sim2_d = -xi_e;
      end
      default: begin
        sre2_d = '0;
        sim2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act2_q <= act1_q;
      mre2_q <= SW'(p_rr_q) - SW'(p_ii_q);
      mim2_q <= SW'(p_ri_q) + SW'(p_ir_q);
      nre2_q <= SW'(p_rr_q) + SW'(p_ii_q);
      nim2_q <= SW'(p_ir_q) - SW'(p_ri_q);
      den2_q <= PW'($unsigned(p_yr_q)) + PW'($unsigned(p_yi_q));
      sre2_q <= sre2_d;
      sim2_q <= sim2_d;
    end
  end

  // stage 3: saturate short results, set up the divider
  logic [DW:0]          sat_re, sat_im;
  logic signed [SW-1:0] mag_re, mag_im;
  logic [WW-1:0]        num_re_w, num_im_w, den_w;
  div_ctl_t             ctl_d;
  logic [DW-1:0]        pre_re_d, pre_im_d;

  always_comb begin
    mag_re   = nre2_q[SW-1] ? -nre2_q : nre2_q;
    mag_im   = nim2_q[SW-1] ? -nim2_q : nim2_q;
    num_re_w = WW'(mag_re[PW-1:0]) << FRAC_BITS;
    num_im_w = WW'(mag_im[PW-1:0]) << FRAC_BITS;
    den_w    = WW'(den2_q) << DW;

    unique case (act2_q)
      ACT_ADD, ACT_SUB, ACT_CONJ, ACT_NEG: begin
        sat_re = sat_f({{(SW-DW-1){sre2_q[DW]}}, sre2_q});
        sat_im = sat_f({{(SW-DW-1){sim2_q[DW]}}, sim2_q});
      end
      ACT_MUL: begin
        sat_re = sat_f(mre2_q >>> FRAC_BITS);
        sat_im = sat_f(mim2_q >>> FRAC_BITS);
      end
      default: begin
        sat_re = '0;
        sat_im = '0;
      end
    endcase

    pre_re_d       = sat_re[DW-1:0];
    pre_im_d       = sat_im[DW-1:0];
    ctl_d.is_div   = (act2_q == ACT_DIV);
    ctl_d.dbz      = (den2_q == '0);
    ctl_d.neg_re   = nre2_q[SW-1];
    ctl_d.neg_im   = nim2_q[SW-1];
    // quotient of 2^DW or more saturates whatever its sign
    ctl_d.big_re   = (num_re_w >= den_w);
    ctl_d.big_im   = (num_im_w >= den_w);
    ctl_d.pre_ovf  = sat_re[DW] | sat_im[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o    <= ctl_d;
      pre_re_o <= pre_re_d;
      pre_im_o <= pre_im_d;
      rem_re_o <= num_re_w;
      rem_im_o <= num_im_w;
      den_o    <= den2_q;
    end
  end

endmodule

// ===== sv/cau_div_step.sv =====
// One restoring-division stage: resolve one quotient bit of both parts.
module cau_div_step import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned BIT_POS    = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  div_ctl_t                          ctl_i,
  input  logic [DATA_WIDTH-1:0]             pre_re_i,
  input  logic [DATA_WIDTH-1:0]             pre_im_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_i,
  input  logic [DATA_WIDTH-1:0]             q_re_i,
  input  logic [DATA_WIDTH-1:0]             q_im_i,
  input  logic [2*DATA_WIDTH-1:0]           den_i,
  output logic                              valid_o,
  output div_ctl_t                          ctl_o,
  output logic [DATA_WIDTH-1:0]             pre_re_o,
  output logic [DATA_WIDTH-1:0]             pre_im_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_o,
  output logic [DATA_WIDTH-1:0]             q_re_o,
  output logic [DATA_WIDTH-1:0]             q_im_o,
  output logic [2*DATA_WIDTH-1:0]           den_o
);

  localparam int unsigned WW = 3 * DATA_WIDTH + FRAC_BITS;

  logic [WW-1:0]         dsh;
  logic                  ge_re, ge_im;
  logic [WW-1:0]         rem_re_d, rem_im_d;
  logic [DATA_WIDTH-1:0] q_re_d, q_im_d;

  always_comb begin
    dsh      = WW'(den_i) << BIT_POS;
    ge_re    = (rem_re_i >= dsh);
    ge_im    = (rem_im_i >= dsh);
    rem_re_d = ge_re ? rem_re_i - dsh : rem_re_i;
    rem_im_d = ge_im ? rem_im_i - dsh : rem_im_i;
    q_re_d   = q_re_i;
    q_im_d   = q_im_i;
    q_re_d[BIT_POS] = ge_re;
    q_im_d[BIT_POS] = ge_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o    <= ctl_i;
      pre_re_o <= pre_re_i;
      pre_im_o <= pre_im_i;
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
      den_o    <= den_i;
    end
  end

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: front end, divider chain and output register.
// Pipelined complex ALU on signed fixed point (Q3.12 at default sizes): add, subtract,
// multiply, divide, conjugate and negate, one word accepted per clock while the pipe is
// not stalled. Every word passes through three front-end stages for products and sums,
// one restoring-division stage per quotient bit, and the output register. All operations
// take that same path so results leave in order. The whole pipe advances together; while
// the output word waits, s_axis_tready is low.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // x_re, x_im, y_re, y_im from bit 0 up, zero padded
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // action
  input  logic [2:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // res_re, res_im from bit 0 up, zero padded
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // overflow, div_by_zero from bit 0 up
  output logic [1:0]                             m_axis_tuser
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned WW    = 3 * DATA_WIDTH + FRAC_BITS;
  localparam int unsigned OUT_W = ((2*DATA_WIDTH+7)/8)*8;

  localparam logic [DW-1:0] MaxV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};

  logic en;

  logic [DW:0]    vld;
  div_ctl_t       ctl    [DW+1];
  logic [DW-1:0]  pre_re [DW+1];
  logic [DW-1:0]  pre_im [DW+1];
  logic [WW-1:0]  rem_re [DW+1];
  logic [WW-1:0]  rem_im [DW+1];
  logic [DW-1:0]  q_re   [DW+1];
  logic [DW-1:0]  q_im   [DW+1];
  logic [2*DW-1:0] den   [DW+1];

  logic           out_v_q;
  logic [DW-1:0]  out_re_q, out_im_q, out_re_d, out_im_d;
  logic           out_ovf_q, out_dbz_q, out_ovf_d, out_dbz_d;
  logic [DW:0]    fix_re, fix_im;

  // advance the whole pipe unless the output word is held
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .action_i (s_axis_tuser),
    .x_re_i   (s_axis_tdata[DW-1:0]),
    .x_im_i   (s_axis_tdata[2*DW-1:DW]),
    .y_re_i   (s_axis_tdata[3*DW-1:2*DW]),
    .y_im_i   (s_axis_tdata[4*DW-1:3*DW]),
    .valid_o  (vld[0]),
    .ctl_o    (ctl[0]),
    .pre_re_o (pre_re[0]),
    .pre_im_o (pre_im[0]),
    .rem_re_o (rem_re[0]),
    .rem_im_o (rem_im[0]),
    .den_o    (den[0])
  );

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  for (genvar g = 0; g < DW; g++) begin : g_div
    cau_div_step #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .BIT_POS    (DW - 1 - g)
    ) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (vld[g]),
      .ctl_i    (ctl[g]),
      .pre_re_i (pre_re[g]),
      .pre_im_i (pre_im[g]),
      .rem_re_i (rem_re[g]),
      .rem_im_i (rem_im[g]),
      .q_re_i   (q_re[g]),
      .q_im_i   (q_im[g]),
      .den_i    (den[g]),
      .valid_o  (vld[g+1]),
      .ctl_o    (ctl[g+1]),
      .pre_re_o (pre_re[g+1]),
      .pre_im_o (pre_im[g+1]),
      .rem_re_o (rem_re[g+1]),
      .rem_im_o (rem_im[g+1]),
      .q_re_o   (q_re[g+1]),
      .q_im_o   (q_im[g+1]),
      .den_o    (den[g+1])
    );
  end

  // apply the sign to an unsigned quotient and clamp
  function automatic logic [DW:0] div_fix(input logic [DW-1:0] q, input logic neg,
                                          input logic big);
    logic [DW:0] r;
    if (big) begin
      r = {1'b1, neg ? MinV : MaxV};
    end else if (neg) begin
      r = (q > MinV) ? {1'b1, MinV} : {1'b0, -q};
    end else begin
      r = q[DW-1] ? {1'b1, MaxV} : {1'b0, q};
    end
    return r;
  endfunction

  always_comb begin
    fix_re = div_fix(q_re[DW], ctl[DW].neg_re, ctl[DW].big_re);
    fix_im = div_fix(q_im[DW], ctl[DW].neg_im, ctl[DW].big_im);
    priority if (ctl[DW].is_div && ctl[DW].dbz) begin
      out_re_d  = '0;
      out_im_d  = '0;
      out_ovf_d = 1'b0;
      out_dbz_d = 1'b1;
    end else if (ctl[DW].is_div) begin
      out_re_d  = fix_re[DW-1:0];
      out_im_d  = fix_im[DW-1:0];
      out_ovf_d = fix_re[DW] | fix_im[DW];
      out_dbz_d = 1'b0;
    end else begin
      out_re_d  = pre_re[DW];
      out_im_d  = pre_im[DW];
      out_ovf_d = ctl[DW].pre_ovf;
      out_dbz_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q  <= out_re_d;
      out_im_q  <= out_im_d;
      out_ovf_q <= out_ovf_d;
      out_dbz_q <= out_dbz_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({out_im_q, out_re_q});
  assign m_axis_tuser  = {out_dbz_q, out_ovf_q};

  `CAU_ASSERT_IMP(a_dbz_zero, out_v_q && out_dbz_q, out_re_q == '0 && out_im_q == '0 && !out_ovf_q, "divide by zero word carries data or overflow")
  `CAU_ASSERT_NEXT(a_stall_hold, !en, $stable(vld), "pipe valid bits moved during stall")
  `CAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while held")

endmodule

// ===== sim/testbench.sv =====
// Self-checking stream testbench for the complex arithmetic unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] x_re;
    logic [15:0] x_im;
    logic [15:0] y_re;
    logic [15:0] y_im;
  } op_t;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        ovf;
    logic        dbz;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  complex_arithmetic_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  op_t  pending_ops[$];
  res_t expected_res[$];
  int   mismatches = 0;
  bit   hold_send = 0;
  bit   quiet = 0;

  // registered accept flag from the last rising edge
  logic s_axis_tready_q = 1'b0;

  function automatic logic [15:0] saturate(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic res_t compute_result(input op_t op);
    longint xr, xi, yr, yi, re, im, den;
    res_t r;
    xr = longint'($signed(op.x_re));
    xi = longint'($signed(op.x_im));
    yr = longint'($signed(op.y_re));
    yi = longint'($signed(op.y_im));
    re = 0;
    im = 0;
    r = '0;
    case (op.action)
      ACT_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      ACT_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      ACT_MUL: begin
        re = (xr * yr - xi * yi) >>> 12;
        im = (xr * yi + xi * yr) >>> 12;
      end
      ACT_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.dbz = 1'b1;
        else begin
          // SV integer division truncates toward zero
          re = ((xr * yr + xi * yi) * 4096) / den;
          im = ((xi * yr - xr * yi) * 4096) / den;
        end
      end
      ACT_CONJ: begin
        re = xr;
        im = -xi;
      end
      ACT_NEG: begin
        re = -xr;
        im = -xi;
      end
      default: ;
    endcase
    r.re = saturate(re, r.ovf);
    r.im = saturate(im, r.ovf);
    return r;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 16383)) - 8192);
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_op(input logic [2:0] a, input logic [15:0] xr, xi, yr, yi);
    op_t op;
    op = '{a, xr, xi, yr, yi};
    pending_ops.push_back(op);
  endtask

  // driver: change inputs on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_ops.size() > 0 && !hold_send && (quiet || $urandom_range(0, 99) >= 9)) begin
          op_t op;
          op = pending_ops.pop_front();
          s_axis_tdata  <= {op.y_im, op.y_re, op.x_im, op.x_re};
          s_axis_tuser  <= op.action;
          s_axis_tvalid <= 1'b1;
          expected_res.push_back(compute_result(op));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_t got, want;
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0], m_axis_tuser[1]};
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: re %h/%h im %h/%h ovf %b/%b dbz %b/%b (exp/act)",
                     want.re, got.re, want.im, got.im, want.ovf, got.ovf,
                     want.dbz, got.dbz);
        end
      end
    end
  end

  initial begin
    int n;
    logic [2:0] a;
    // directed: extremes, every action, unused codes, zero divisor, negating the minimum
    push_op(ACT_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    push_op(ACT_ADD, 16'h1000, 16'hf000, 16'h0800, 16'h0800);
    push_op(ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    push_op(ACT_SUB, 16'h1234, 16'h0001, 16'h1234, 16'hffff);
    push_op(ACT_MUL, 16'h1000, 16'h1000, 16'h1000, 16'hf000);
    push_op(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_op(ACT_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    push_op(ACT_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    push_op(ACT_DIV, 16'h1000, 16'h2000, 16'h0000, 16'h0000);
    push_op(ACT_DIV, 16'h1000, 16'h0000, 16'h2000, 16'h0000);
    push_op(ACT_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    push_op(ACT_DIV, 16'hf000, 16'h0800, 16'h0000, 16'h1000);
    push_op(ACT_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_op(ACT_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff);
    push_op(ACT_CONJ, 16'h8000, 16'h8000, 16'h1111, 16'h2222);
    push_op(ACT_CONJ, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    push_op(ACT_NEG, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    push_op(ACT_NEG, 16'h0001, 16'h8000, 16'h0000, 16'h0000);
    push_op(3'd6, 16'h7fff, 16'h8000, 16'h1234, 16'h5678);
    push_op(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pause the sender until every result is back
    wait (pending_ops.size() == 0);
    hold_send = 1;
    wait (expected_res.size() == 0 && !s_axis_tvalid);
    repeat (30) @(posedge clk_i);
    hold_send = 0;
    for (n = 0; n < 450; n++) begin
      a = ($urandom_range(0, 29) == 0) ? 3'(6 + $urandom_range(0, 1)) : 3'($urandom_range(0, 5));
      if (a == ACT_DIV && $urandom_range(0, 9) == 0)
        push_op(a, pick_value(), pick_value(), 16'h0000, 16'h0000);
      else
        push_op(a, pick_value(), pick_value(), pick_value(), pick_value());
      if (n == 150) begin
        wait (pending_ops.size() == 0);
        quiet = 1;
      end
      if (n == 300) begin
        wait (pending_ops.size() == 0);
        quiet = 0;
      end
    end
    wait (pending_ops.size() == 0);
    wait (expected_res.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
